@@ hw/rtl/epdd_pkg.sv @@
// Package for the echo pulse distance display.
// Shared widths, limits, register codes and the configuration struct.
// No dependencies.
package epdd_pkg;

  localparam int unsigned CLOCK_HZ_DEF   = 50000000;
  localparam int unsigned PULSE_BITS_DEF = 24;

  localparam int unsigned SPEED_W  = 9;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned MM_W     = 14;
  localparam int unsigned INCH_W   = 11;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [DIGIT_W-1:0] BLANK_CODE  = 4'd10;
  localparam logic [MM_W-1:0]    MM_LIMIT    = 14'd9999;
  localparam logic [INCH_W-1:0]  INCH_LIMIT  = 11'd1199;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 9'd343;

  typedef enum logic {
    REG_UNIT_MODE = 1'b0,
    REG_SPEED_MPS = 1'b1
  } epdd_reg_t;

  typedef struct packed {
    logic               unit_mode;
    logic [SPEED_W-1:0] speed_mps;
  } epdd_cfg_t;

endpackage

@@ hw/rtl/epdd_regs.sv @@
// APB configuration registers: display mode and speed of sound.
// Depends on epdd_pkg.
module epdd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [epdd_pkg::APB_AW-1:0]  paddr,
  input  logic [epdd_pkg::APB_DW-1:0]  pwdata,
  output logic [epdd_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output epdd_pkg::epdd_cfg_t          cfg
);

  epdd_pkg::epdd_reg_t reg_sel;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_sel = epdd_pkg::epdd_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unit_mode <= 1'b0;
      cfg.speed_mps <= epdd_pkg::SPEED_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        epdd_pkg::REG_UNIT_MODE: cfg.unit_mode <= pwdata[0];
        epdd_pkg::REG_SPEED_MPS: cfg.speed_mps <= pwdata[epdd_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      epdd_pkg::REG_UNIT_MODE: prdata = epdd_pkg::APB_DW'(cfg.unit_mode);
      epdd_pkg::REG_SPEED_MPS: prdata = epdd_pkg::APB_DW'(cfg.speed_mps);
      default:                 prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/epdd_range.sv @@
// Pulse width to millimetres, saturated at 9999: product, reciprocal
// estimate, one-step correction. Depends on epdd_pkg.
module epdd_range #(
  parameter int unsigned CLOCK_HZ   = epdd_pkg::CLOCK_HZ_DEF,
  parameter int unsigned PULSE_BITS = epdd_pkg::PULSE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         ticks_valid,
  input  logic [PULSE_BITS-1:0]        ticks,
  input  logic [epdd_pkg::SPEED_W-1:0] speed,
  output logic                         mm_valid,
  output logic [epdd_pkg::MM_W-1:0]    mm
);

  localparam int unsigned MM_W  = epdd_pkg::MM_W;
  localparam int unsigned P_W   = PULSE_BITS + epdd_pkg::SPEED_W;
  // mm = floor(500 * ticks * speed / CLOCK_HZ); saturates once the product reaches 20 * CLOCK_HZ
  localparam int unsigned MM_SCALE = 500;
  localparam longint unsigned SAT_LIM = 64'd20 * 64'(CLOCK_HZ);
  localparam int unsigned K     = $clog2(SAT_LIM);
  localparam int unsigned EXT_W = (P_W > K + 1) ? P_W : K + 1;
  localparam longint unsigned RECIP = (64'(MM_SCALE) << K) / 64'(CLOCK_HZ);
  localparam int unsigned R_W   = $clog2(RECIP + 1);
  localparam int unsigned N_W   = K + 9;
  localparam logic [R_W-1:0] RECIP_V = R_W'(RECIP);

  logic [P_W-1:0]     prod1;
  logic               v1;
  logic [EXT_W-1:0]   prod_ext;
  logic [K-1:0]       pc;
  logic [K+R_W-1:0]   qprod;
  logic               sat_next;
  logic [MM_W-1:0]    qe_next;
  logic [N_W-1:0]     n_next;

  logic               v2, sat2;
  logic [MM_W-1:0]    qe2;
  logic [N_W-1:0]     n2;

  logic               v3, sat3;
  logic [MM_W-1:0]    qe3;
  logic [N_W-1:0]     n3, qc3;

  logic [N_W-1:0]     resid;
  logic               carry;

  assign prod_ext = EXT_W'(prod1);
  assign sat_next = prod_ext >= EXT_W'(SAT_LIM);
  assign pc       = prod_ext[K-1:0];
  assign qprod    = (K+R_W)'(pc) * (K+R_W)'(RECIP_V);
  assign qe_next  = MM_W'(qprod >> K);
  assign n_next   = N_W'(pc) * N_W'(MM_SCALE);

  assign resid = n3 - qc3;
  assign carry = resid >= N_W'(CLOCK_HZ);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      mm_valid <= 1'b0;
    end else if (en) begin
      v1       <= ticks_valid;
      v2       <= v1;
      v3       <= v2;
      mm_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= P_W'(ticks) * P_W'(speed);
      sat2  <= sat_next;
      qe2   <= qe_next;
      n2    <= n_next;
      sat3  <= sat2;
      qe3   <= qe2;
      n3    <= n2;
      qc3   <= N_W'(qe2) * N_W'(CLOCK_HZ);
      mm    <= sat3 ? epdd_pkg::MM_LIMIT : qe3 + MM_W'(carry);
    end
  end

endmodule

@@ hw/rtl/epdd_digits.sv @@
// Millimetres to four display digits and colon, in mm or feet:inches form,
// with leading-zero blanking. Depends on epdd_pkg.
module epdd_digits (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         mm_valid,
  input  logic [epdd_pkg::MM_W-1:0]    mm,
  input  logic                         unit_mode,
  output logic                         disp_valid,
  output logic [epdd_pkg::DIGIT_W-1:0] digit_zero,
  output logic [epdd_pkg::DIGIT_W-1:0] digit_one,
  output logic [epdd_pkg::DIGIT_W-1:0] digit_two,
  output logic [epdd_pkg::DIGIT_W-1:0] digit_three,
  output logic                         colon_lit
);

  localparam int unsigned MM_W   = epdd_pkg::MM_W;
  localparam int unsigned INCH_W = epdd_pkg::INCH_W;
  localparam int unsigned DW     = epdd_pkg::DIGIT_W;
  localparam int unsigned FT_W   = 7;

  // reciprocal constants, exact over the ranges used here
  localparam logic [18:0] INCH_RECIP = 19'd330265; // 5 * ceil(2^23 / 127)
  localparam logic [13:0] R10        = 14'd13108;  // >> 17
  localparam logic [13:0] R100       = 14'd10486;  // >> 20
  localparam logic [14:0] R1000      = 15'd16778;  // >> 24
  localparam logic [12:0] R12        = 13'd5462;   // >> 16
  localparam logic [6:0]  R10_SMALL  = 7'd103;     // >> 10

  // stage 5
  logic [32:0]       inch_prod;
  logic [27:0]       q10_prod;
  logic [27:0]       q100_prod;
  logic [28:0]       q1000_prod;
  logic [INCH_W-1:0] inch_raw;
  logic              v5;
  logic [MM_W-1:0]   mm5;
  logic [INCH_W-1:0] inch5;
  logic [9:0]        q10_5;
  logic [6:0]        q100_5;
  logic [DW-1:0]     q1000_5;

  // stage 6
  logic [23:0]       feet_prod;
  logic [MM_W-1:0]   mmd0_full, mmd1_full, mmd2_full;
  logic              v6;
  logic [INCH_W-1:0] inch6;
  logic [FT_W-1:0]   feet6;
  logic [DW-1:0]     mmd6 [4];

  // stage 7
  logic [INCH_W-1:0] rem_full;
  logic [13:0]       ft_tens_prod;
  logic              v7;
  logic [DW-1:0]     rem7;
  logic [FT_W-1:0]   feet7;
  logic [DW-1:0]     ft_tens7;
  logic [DW-1:0]     mmd7 [4];

  // stage 8
  logic [FT_W-1:0]   ft_ones_full;
  logic              in_tens;
  logic [DW-1:0]     raw [4];
  logic              b3, b2, b1;

  assign inch_prod  = 33'(mm) * 33'(INCH_RECIP);
  assign q10_prod   = 28'(mm) * 28'(R10);
  assign q100_prod  = 28'(mm) * 28'(R100);
  assign q1000_prod = 29'(mm) * 29'(R1000);
  assign inch_raw   = INCH_W'(inch_prod >> 23);

  always_ff @(posedge clk) begin
    if (en) begin
      mm5     <= mm;
      inch5   <= (inch_raw > epdd_pkg::INCH_LIMIT) ? epdd_pkg::INCH_LIMIT : inch_raw;
      q10_5   <= 10'(q10_prod >> 17);
      q100_5  <= 7'(q100_prod >> 20);
      q1000_5 <= DW'(q1000_prod >> 24);
    end
  end

  assign feet_prod = 24'(inch5) * 24'(R12);
  assign mmd0_full = mm5 - MM_W'(q10_5) * MM_W'(10);
  assign mmd1_full = MM_W'(q10_5) - MM_W'(q100_5) * MM_W'(10);
  assign mmd2_full = MM_W'(q100_5) - MM_W'(q1000_5) * MM_W'(10);

  always_ff @(posedge clk) begin
    if (en) begin
      inch6   <= inch5;
      feet6   <= FT_W'(feet_prod >> 16);
      mmd6[0] <= DW'(mmd0_full);
      mmd6[1] <= DW'(mmd1_full);
      mmd6[2] <= DW'(mmd2_full);
      mmd6[3] <= q1000_5;
    end
  end

  assign rem_full     = inch6 - INCH_W'(feet6) * INCH_W'(12);
  assign ft_tens_prod = 14'(feet6) * 14'(R10_SMALL);

  always_ff @(posedge clk) begin
    if (en) begin
      rem7     <= DW'(rem_full);
      feet7    <= feet6;
      ft_tens7 <= DW'(ft_tens_prod >> 10);
      mmd7     <= mmd6;
    end
  end

  assign ft_ones_full = feet7 - FT_W'(ft_tens7) * FT_W'(10);
  assign in_tens      = rem7 >= DW'(10);

  always_comb begin
    if (unit_mode) begin
      raw[0] = in_tens ? rem7 - DW'(10) : rem7;
      raw[1] = DW'(in_tens);
      raw[2] = DW'(ft_ones_full);
      raw[3] = ft_tens7;
      if (raw[2] != '0 && !in_tens) begin
        raw[1] = epdd_pkg::BLANK_CODE;
      end
    end else begin
      raw = mmd7;
    end
    b3 = raw[3] == '0;
    b2 = b3 && raw[2] == '0;
    b1 = b2 && raw[1] == '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      digit_zero  <= raw[0];
      digit_one   <= b1 ? epdd_pkg::BLANK_CODE : raw[1];
      digit_two   <= b2 ? epdd_pkg::BLANK_CODE : raw[2];
      digit_three <= b3 ? epdd_pkg::BLANK_CODE : raw[3];
      colon_lit   <= unit_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5         <= 1'b0;
      v6         <= 1'b0;
      v7         <= 1'b0;
      disp_valid <= 1'b0;
    end else if (en) begin
      v5         <= mm_valid;
      v6         <= v5;
      v7         <= v6;
      disp_valid <= v7;
    end
  end

endmodule

@@ hw/rtl/echo_pulse_distance_display.sv @@
// Echo pulse distance display, top level: input skid stage, distance and digit pipelines,
// APB registers. Depends on epdd_pkg, epdd_regs, epdd_range, epdd_digits.
//
// Usage:
//   pulse channel   : pulse_valid / pulse_ready, payload pulse_ticks (echo width in clocks).
//   display channel : display_valid / display_ready, payload four digits (10 = blank) and
//                     colon_lit. One display transaction per pulse transaction, in order.
//   APB port        : unit_mode at 0x0, speed_mps at 0x4; write only while idle.
// Timing:
//   A pulse passes the input register, then the eight register stages (product,
//   reciprocal estimate, correction, mm, digit split) before it reaches display_valid.
//   Throughput is one transaction per cycle while display_ready stays high.
// Stalls:
//   With display_valid high and display_ready low the whole pipeline holds; one further
//   pulse is caught in the skid register, then pulse_ready drops. After the stall clears,
//   pulse_ready returns in the next cycle, once the skid register has drained.
// Reset:
//   rst clears all valid flags, the skid flag among them, and loads unit_mode = 0,
//   speed_mps = 343. Payload registers are not reset.
module echo_pulse_distance_display #(
  parameter int unsigned CLOCK_HZ   = epdd_pkg::CLOCK_HZ_DEF,
  parameter int unsigned PULSE_BITS = epdd_pkg::PULSE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pulse_valid,
  output logic                         pulse_ready,
  input  logic [PULSE_BITS-1:0]        pulse_ticks,
  output logic                         display_valid,
  input  logic                         display_ready,
  output logic [epdd_pkg::DIGIT_W-1:0] digit_zero,
  output logic [epdd_pkg::DIGIT_W-1:0] digit_one,
  output logic [epdd_pkg::DIGIT_W-1:0] digit_two,
  output logic [epdd_pkg::DIGIT_W-1:0] digit_three,
  output logic                         colon_lit,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [epdd_pkg::APB_AW-1:0]  paddr,
  input  logic [epdd_pkg::APB_DW-1:0]  pwdata,
  output logic [epdd_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  epdd_pkg::epdd_cfg_t     cfg;
  logic                    en;
  logic                    take;
  logic                    skid_valid;
  logic [PULSE_BITS-1:0]   skid_ticks;
  logic                    v0;
  logic [PULSE_BITS-1:0]   ticks0;
  logic                    mm_valid;
  logic [epdd_pkg::MM_W-1:0] mm;

  assign en          = !display_valid || display_ready;
  assign pulse_ready = !skid_valid;
  assign take        = pulse_valid && pulse_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
      v0         <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
      v0         <= skid_valid || take;
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ticks0 <= skid_valid ? skid_ticks : pulse_ticks;
    end else if (take) begin
      skid_ticks <= pulse_ticks;
    end
  end

  epdd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  epdd_range #(
    .CLOCK_HZ   (CLOCK_HZ),
    .PULSE_BITS (PULSE_BITS)
  ) u_range (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .ticks_valid (v0),
    .ticks       (ticks0),
    .speed       (cfg.speed_mps),
    .mm_valid    (mm_valid),
    .mm          (mm)
  );

  epdd_digits u_digits (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .mm_valid     (mm_valid),
    .mm           (mm),
    .unit_mode    (cfg.unit_mode),
    .disp_valid   (display_valid),
    .digit_zero   (digit_zero),
    .digit_one    (digit_one),
    .digit_two    (digit_two),
    .digit_three  (digit_three),
    .colon_lit    (colon_lit)
  );

endmodule

@@ hw/rtl/epdd_checker.sv @@
// Port-level checks on the display channel of the echo pulse distance display.
// Depends on epdd_pkg; bound to echo_pulse_distance_display below.
module epdd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         display_valid,
  input logic                         display_ready,
  input logic [epdd_pkg::DIGIT_W-1:0] digit_zero,
  input logic [epdd_pkg::DIGIT_W-1:0] digit_one,
  input logic [epdd_pkg::DIGIT_W-1:0] digit_two,
  input logic [epdd_pkg::DIGIT_W-1:0] digit_three,
  input logic                         colon_lit
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    display_valid && !display_ready |=> display_valid && $stable(digit_zero) &&
      $stable(digit_one) && $stable(digit_two) && $stable(digit_three) && $stable(colon_lit))
    else $error("display transaction changed while stalled");

  a_units: assert property (@(posedge clk) disable iff (rst)
    display_valid |-> digit_zero <= 4'd9)
    else $error("rightmost digit blanked or out of range");

  a_mm_blank: assert property (@(posedge clk) disable iff (rst)
    display_valid && !colon_lit && digit_three != epdd_pkg::BLANK_CODE |->
      digit_two != epdd_pkg::BLANK_CODE && digit_one != epdd_pkg::BLANK_CODE)
    else $error("blank digit below a shown leading digit");

  a_inch_tens: assert property (@(posedge clk) disable iff (rst)
    display_valid && colon_lit |->
      digit_one == 4'd0 || digit_one == 4'd1 || digit_one == epdd_pkg::BLANK_CODE)
    else $error("inches tens digit out of range");

  a_reset: assert property (@(posedge clk)
    rst |=> !display_valid)
    else $error("display valid after reset");

endmodule

bind echo_pulse_distance_display epdd_checker u_epdd_checker (.*);
